/* rtl/core/vabd_pkg.sv */
// Shared types and constants for the vehicle arrival band detector.
`default_nettype none

package vabd_pkg;

    localparam int ROW_W  = 10;
    localparam int H_W    = 11;
    localparam int CNT_W  = 14;
    localparam int DIFF_W = 13;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Band A spans roi_height-16 .. roi_height-10, band B roi_height-8 .. roi_height-1,
    // written as distances d = roi_height - row.
    localparam logic signed [DIFF_W-1:0] BAND_A_FAR  = 13'sd16;
    localparam logic signed [DIFF_W-1:0] BAND_A_NEAR = 13'sd10;
    localparam logic signed [DIFF_W-1:0] BAND_B_FAR  = 13'sd8;
    localparam logic signed [DIFF_W-1:0] BAND_B_NEAR = 13'sd1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [H_W-1:0]   ROI_HEIGHT_RST = 11'd64;
    localparam logic [CNT_W-1:0] MIN_COUNT_RST  = 14'd50;
    localparam logic [CNT_W-1:0] QUIET_MAX_RST  = 14'd10;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_ROI_HEIGHT = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_MIN_COUNT  = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_QUIET_MAX  = 4'h8;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             in_mask;
        logic             moving;
        logic             frame_end;
    } pix_t;

    typedef struct packed {
        logic vehicle_present;
        logic vehicle_arrived;
    } res_t;

    typedef struct packed {
        logic [H_W-1:0]   roi_height;
        logic [CNT_W-1:0] min_count;
        logic [CNT_W-1:0] quiet_max;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/vehicle_arrival_band_detector_core.sv */
// Top level of the vehicle arrival band detector: pixel input, APB registers, result output.
// Order: a frame_end pixel is first held in the pixel register; its result enters the
//   result register once that register is free, and transfers out from there.
// Throughput: one pixel per cycle; the pixel register only holds when it carries a
//   frame_end and the result register is still waiting on a stalled consumer.
// Reset: rst_n clears both band counters, the presence flag and all valid bits, and
//   loads roi_height=64, min_count=50, quiet_max=10.
`default_nettype none

module vehicle_arrival_band_detector_core
    import vabd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // pixel channel
    input  wire logic              pix_valid,
    output logic                   pix_stall,
    input  wire pix_t              pix,
    // result channel
    output logic                   res_valid,
    input  wire logic              res_stall,
    output res_t                   res,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr)
                ADDR_ROI_HEIGHT: cfg_next.roi_height = pwdata[H_W-1:0];
                ADDR_MIN_COUNT:  cfg_next.min_count  = pwdata[CNT_W-1:0];
                ADDR_QUIET_MAX:  cfg_next.quiet_max  = pwdata[CNT_W-1:0];
                default:         cfg_next = cfg_reg;   // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_ROI_HEIGHT: prdata = {{(DATA_W-H_W){1'b0}}, cfg_reg.roi_height};
            ADDR_MIN_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.min_count};
            ADDR_QUIET_MAX:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.quiet_max};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.roi_height <= ROI_HEIGHT_RST;
            cfg_reg.min_count  <= MIN_COUNT_RST;
            cfg_reg.quiet_max  <= QUIET_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel register and result register
    // ------------------------------------------------------------------
    logic pix_valid_reg, pix_valid_next;
    pix_t pix_reg;
    logic res_valid_reg, res_valid_next;
    res_t res_reg;
    logic out_free;
    logic advance;
    logic step;
    res_t decision;

    // The result register can take a new result when empty or being drained.
    assign out_free = !res_valid_reg || !res_stall;
    // Only a frame_end pixel needs room in the result register; others always advance.
    assign advance  = !pix_valid_reg || !pix_reg.frame_end || out_free;
    assign step     = pix_valid_reg && advance;
    assign pix_stall = !advance;

    assign pix_valid_next = advance ? pix_valid : pix_valid_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step && pix_reg.frame_end)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (advance)
            pix_reg <= pix;
        if (step && pix_reg.frame_end)
            res_reg <= decision;
    end

    // Count the registered pixel and form the frame decision
    vabd_band_stage u_band_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pix      (pix_reg),
        .step     (step),
        .decision (decision)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An arrival pulse always comes with the presence flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.vehicle_present || !res.vehicle_arrived))
        else $error("arrival reported without presence");

    // Input holds only for a frame_end pixel facing a blocked result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (pix_valid_reg && pix_reg.frame_end && res_valid_reg && res_stall))
        else $error("input stalled without cause");

    // A frame_end pixel that advances yields a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && pix_reg.frame_end && advance) |=> res_valid)
        else $error("frame result lost");

endmodule

`default_nettype wire

/* rtl/core/vabd_band_stage.sv */
// Band counters, presence flag and per-frame decision.
`default_nettype none

module vabd_band_stage
    import vabd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire pix_t pix,
    input  wire logic step,
    output res_t      decision
);

    logic [CNT_W-1:0] band_a_reg, band_a_next;
    logic [CNT_W-1:0] band_b_reg, band_b_next;
    logic             present_reg, present_next;

    logic signed [DIFF_W-1:0] row_gap;
    logic                     hit;
    logic                     in_a;
    logic                     in_b;
    logic [CNT_W-1:0]         a_cnt;
    logic [CNT_W-1:0]         b_cnt;
    logic                     set_flag;
    logic                     clr_flag;
    logic                     flag;

    assign row_gap = signed'({2'b00, cfg.roi_height}) - signed'({3'b000, pix.row_index});
    assign hit  = pix.in_mask && pix.moving;
    assign in_a = hit && (row_gap >= BAND_A_NEAR) && (row_gap <= BAND_A_FAR);
    assign in_b = hit && (row_gap >= BAND_B_NEAR) && (row_gap <= BAND_B_FAR);

    // Saturating increment, counting this pixel before the decision
    assign a_cnt = (in_a && band_a_reg != CNT_MAX) ? band_a_reg + 1'b1 : band_a_reg;
    assign b_cnt = (in_b && band_b_reg != CNT_MAX) ? band_b_reg + 1'b1 : band_b_reg;

    assign set_flag = (a_cnt > b_cnt) && (a_cnt > cfg.min_count);
    assign clr_flag = ((b_cnt > a_cnt) && (b_cnt > cfg.min_count) && (a_cnt < cfg.quiet_max))
                   || (a_cnt == '0 && b_cnt == '0);
    assign flag     = clr_flag ? 1'b0 : (set_flag ? 1'b1 : present_reg);

    assign decision.vehicle_present = flag;
    assign decision.vehicle_arrived = flag && !present_reg;

    always_comb
    begin
        band_a_next  = band_a_reg;
        band_b_next  = band_b_reg;
        present_next = present_reg;
        if (step)
        begin
            if (pix.frame_end)
            begin
                band_a_next  = '0;
                band_b_next  = '0;
                present_next = flag;
            end
            else
            begin
                band_a_next = a_cnt;
                band_b_next = b_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_a_reg  <= '0;
            band_b_reg  <= '0;
            present_reg <= 1'b0;
        end
        else
        begin
            band_a_reg  <= band_a_next;
            band_b_reg  <= band_b_next;
            present_reg <= present_next;
        end
    end

endmodule

`default_nettype wire

/* tb/vabd_checker.sv */
`timescale 1ns / 100ps
// Checker for the band detector: tracks register writes, predicts frame decisions, compares results.

module vabd_checker
    import vabd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    input  logic              pix_stall,
    input  pix_t              pix,
    input  logic              res_valid,
    input  logic              res_stall,
    input  res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                fail_count,
    output int                pending_results
);

    localparam logic [CNT_W-1:0] BAND_CEILING = 14'd16383;

    logic [H_W-1:0]   roi_height;
    logic [CNT_W-1:0] min_count;
    logic [CNT_W-1:0] quiet_max;
    logic [CNT_W-1:0] band_a;
    logic [CNT_W-1:0] band_b;
    logic             present;
    res_t             frame_verdicts[$];
    int               mismatches;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == BAND_CEILING) ? c : c + 1'b1;
    endfunction

    // Count one pixel into its band; on frame end, decide presence and queue the verdict.
    task automatic tally_pixel(input pix_t p);
        int   row;
        int   h;
        logic was_present;
        res_t verdict;
        row = int'(p.row_index);
        h   = int'(roi_height);
        if (p.in_mask && p.moving && row < h) begin
            if (row >= h - 16 && row <= h - 10)
                band_a = bump(band_a);
            else if (row >= h - 8)
                band_b = bump(band_b);
        end
        if (p.frame_end) begin
            was_present = present;
            if (band_a > band_b && band_a > min_count)
                present = 1'b1;
            if ((band_b > band_a && band_b > min_count && band_a < quiet_max)
                || (band_a == '0 && band_b == '0))
                present = 1'b0;
            verdict.vehicle_present = present;
            verdict.vehicle_arrived = present && !was_present;
            frame_verdicts.push_back(verdict);
            band_a = '0;
            band_b = '0;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (frame_verdicts.size() == 0) begin
            $error("unexpected result: vehicle_present=%0b vehicle_arrived=%0b",
                   got.vehicle_present, got.vehicle_arrived);
            mismatches++;
        end else begin
            want = frame_verdicts.pop_front();
            if (got.vehicle_present !== want.vehicle_present) begin
                $error("vehicle_present: expected %0b, got %0b",
                       want.vehicle_present, got.vehicle_present);
                mismatches++;
            end
            if (got.vehicle_arrived !== want.vehicle_arrived) begin
                $error("vehicle_arrived: expected %0b, got %0b",
                       want.vehicle_arrived, got.vehicle_arrived);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            roi_height = ROI_HEIGHT_RST;
            min_count  = MIN_COUNT_RST;
            quiet_max  = QUIET_MAX_RST;
            band_a     = '0;
            band_b     = '0;
            present    = 1'b0;
            mismatches = 0;
            frame_verdicts.delete();
            fail_count      <= 0;
            pending_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_ROI_HEIGHT: roi_height = pwdata[H_W-1:0];
                    ADDR_MIN_COUNT:  min_count  = pwdata[CNT_W-1:0];
                    ADDR_QUIET_MAX:  quiet_max  = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // A result never belongs to the pixel taken at the same edge, so compare first.
            if (res_valid && !res_stall)
                check_result(res);
            if (pix_valid && !pix_stall)
                tally_pixel(pix);
            fail_count      <= mismatches;
            pending_results <= frame_verdicts.size();
        end
    end

endmodule

/* tb/vehicle_arrival_band_detector_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the band detector: pixel and register stimulus, result stalls, verdict.

module vehicle_arrival_band_detector_core_tb;
    import vabd_pkg::*;

    // Address that maps to no register; writes there must leave the settings alone.
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;
    // Cycles to let pass after the last expected result before touching registers.
    localparam int SETTLE_CYCLES = 6;

    typedef enum int {
        FRAME_ARRIVE,
        FRAME_LEAVE,
        FRAME_MIXED,
        FRAME_QUIET,
        FRAME_NOISE
    } frame_kind_e;

    logic              clk;
    logic              rst_n;
    logic              pix_valid;
    logic              pix_stall;
    pix_t              pix;
    logic              res_valid;
    logic              res_stall;
    res_t              res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_results;

    // When set, neither side inserts gaps or stalls.
    bit steady;
    // Current region height, kept only to aim rows at the bands.
    int cur_height;

    vehicle_arrival_band_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    vabd_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix_valid       (pix_valid),
        .pix_stall       (pix_stall),
        .pix             (pix),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a transfer never completes.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one pixel after a random gap and hold it until the transfer happens.
    // Valid is only lowered when a gap is taken, so back-to-back pixels keep it high.
    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic mask,
                              input logic mov, input logic fe);
        int gap;
        gap = steady ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= '{row_index: row, in_mask: mask, moving: mov, frame_end: fe};
        do @(posedge clk); while (pix_stall);
    endtask

    // Drop valid and wait for every predicted verdict to come out, then let the
    // pipeline settle so a register write cannot overlap work in flight.
    task automatic drain_results();
        pix_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle, then idle so writes never run back to back.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_ROI_HEIGHT)
            cur_height = int'(data[H_W-1:0]);
    endtask

    task automatic reconfigure(input int height, input int min_cnt, input int quiet);
        drain_results();
        write_reg(ADDR_ROI_HEIGHT, DATA_W'(height));
        write_reg(ADDR_MIN_COUNT, DATA_W'(min_cnt));
        write_reg(ADDR_QUIET_MAX, DATA_W'(quiet));
    endtask

    // Pick a row a random distance above the region bottom; fall back to any row
    // when the region is too short for that distance.
    function automatic logic [ROW_W-1:0] near_bottom(input int lo, input int hi);
        int offset;
        int r;
        offset = $urandom_range(hi, lo);
        r      = cur_height - offset;
        if (r < 0 || r > 1023)
            r = $urandom_range(1023, 0);
        return r[ROW_W-1:0];
    endfunction

    // Send whole frames of shaped content until about n_items pixels have gone out.
    // Arrive and leave frames lean on one band so the presence flag actually toggles; noise
    // frames use any row and drop frame_end at random, so frames merge.
    task automatic run_frames(input int n_items);
        int               sent;
        int               len;
        int               pick;
        frame_kind_e      kind;
        logic [ROW_W-1:0] row;
        logic             mask;
        logic             mov;
        logic             fe;
        sent = 0;
        while (sent < n_items)
        begin
            kind   = frame_kind_e'($urandom_range(4, 0));
            len    = ($urandom_range(7, 0) == 0) ? 1 : $urandom_range(40, 2);
            steady = ($urandom_range(7, 0) == 0);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(9, 0);
                mask = ($urandom_range(7, 0) != 0);
                mov  = ($urandom_range(7, 0) != 0);
                fe   = (i == len - 1);
                case (kind)
                    FRAME_ARRIVE: row = (pick < 8) ? near_bottom(10, 16) : near_bottom(1, 8);
                    FRAME_LEAVE:  row = (pick < 8) ? near_bottom(1, 8) : near_bottom(10, 16);
                    FRAME_MIXED:  row = near_bottom(1, 17);
                    FRAME_QUIET:
                    begin
                        row = near_bottom(1, 16);
                        mov = (pick == 0);
                    end
                    default:
                    begin
                        row  = ROW_W'($urandom_range(1023, 0));
                        mask = 1'($urandom_range(1, 0));
                        mov  = 1'($urandom_range(1, 0));
                        fe   = ($urandom_range(15, 0) == 0);
                    end
                endcase
                send_pixel(row, mask, mov, fe);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // Result side: stall a random number of cycles per result, then take it.
    initial
    begin
        int hold;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(11, 0);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        steady     = 1'b0;
        cur_height = int'(ROI_HEIGHT_RST);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (height 64): band A is rows 48..54, band B rows 56..63.
        // Row 0 is above both bands; empty counts clear the flag.
        send_pixel(10'd0, 1'b1, 1'b1, 1'b1);
        // Row past the region, the gap row between the bands, and pixels that
        // fail the mask or the motion test: none of them count.
        send_pixel(10'd1023, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd55, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd63, 1'b0, 1'b1, 1'b0);
        send_pixel(10'd48, 1'b1, 1'b0, 1'b0);
        // A single band A pixel stays under the default threshold.
        send_pixel(10'd54, 1'b1, 1'b1, 1'b1);

        // Lower the thresholds so a few pixels decide.
        reconfigure(64, 2, 1);
        // Arrival: three in band A beat one in band B.
        send_pixel(10'd48, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd51, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd54, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd63, 1'b1, 1'b1, 1'b1);
        // Weak frame holds the flag without a new arrival.
        send_pixel(10'd50, 1'b1, 1'b1, 1'b1);
        // Departure: band B busy, band A quiet.
        send_pixel(10'd56, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd60, 1'b1, 1'b1, 1'b0);
        send_pixel(10'd63, 1'b1, 1'b1, 1'b1);
        // Frame end on an uncounted row with nothing else.
        send_pixel(10'd1023, 1'b1, 1'b1, 1'b1);

        // Random phases over several settings, extremes included. The write to an
        // unmapped address must change nothing.
        reconfigure(16, 0, 8192);
        write_reg(ADDR_UNMAPPED, '1);
        run_frames(220);

        reconfigure(1024, 8192, 0);
        run_frames(150);

        // Region shorter than the bands: only non-negative rows count.
        reconfigure(10, 1, 3);
        run_frames(220);

        reconfigure($urandom_range(1024, 16), $urandom_range(12, 0), $urandom_range(12, 0));
        run_frames(130);
        // Hold the sender until every verdict is out, then carry on.
        drain_results();
        run_frames(130);

        reconfigure(64, 50, 10);
        write_reg(ADDR_MIN_COUNT, DATA_W'($urandom_range(6, 0)));
        run_frames(250);

        drain_results();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/vabd_pkg.sv
rtl/core/vabd_band_stage.sv
rtl/core/vehicle_arrival_band_detector_core.sv
tb/vabd_checker.sv
tb/vehicle_arrival_band_detector_core_tb.sv
